// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the depth pixel unit.
// Synthesis builds define SYNTHESIS, which turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/dpw_pkg.sv =====
// Shared types and constants of the depth pixel to world point unit.
// No dependencies; dpw_world_row and the top unit import this package.
`default_nettype none

package dpw_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 63;
  localparam int unsigned ROT_ROW_W  = 54;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned TRANS_W    = 21;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned WORLD_W    = 32;
  // Camera-space point after the pinhole step, signed Q.16 metres.
  localparam int unsigned P_W        = 47;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_A     = 4'd0,
    CFG_ROT_B     = 4'd1,
    CFG_ROT_C     = 4'd2,
    CFG_TRANS     = 4'd3,
    CFG_CENTER    = 4'd4,
    CFG_INV_FX    = 4'd5,
    CFG_INV_FY    = 4'd6,
    CFG_DEPTH_LSB = 4'd7
  } cfg_idx_e;

  localparam logic [ROT_ROW_W-1:0] ROT_A_RST = 54'd68719476736;
  localparam logic [ROT_ROW_W-1:0] ROT_B_RST = 54'd262144;
  localparam logic [ROT_ROW_W-1:0] ROT_C_RST = 54'd1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_index;
    logic [7:0]         depth_code;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } pixel_t;

  typedef struct packed {
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic [7:0]                out_blue;
    logic [7:0]                out_green;
    logic [7:0]                out_red;
  } point_t;

  // Load enables of the three transform stages of one world row.
  typedef struct packed {
    logic en_prod;
    logic en_sum;
    logic en_out;
  } row_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dpw_stream_if.sv =====
// Valid/ready stream interface carrying one payload of type T per transaction.
// Used with dpw_pkg::pixel_t and dpw_pkg::point_t payloads.
`default_nettype none

interface dpw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dpw_world_row.sv =====
// One row of the rigid transform: three products, sum with translation,
// rounding to Q16.16 and saturation. Depends on dpw_pkg.
`default_nettype none

module dpw_world_row (
  input  logic                                clk_i,
  input  dpw_pkg::row_ctl_t                   ctl_i,
  input  logic [dpw_pkg::ROT_ROW_W-1:0]       coef_row_i,
  input  logic signed [dpw_pkg::TRANS_W-1:0]  trans_i,
  input  logic signed [dpw_pkg::P_W-1:0]      p0_i,
  input  logic signed [dpw_pkg::P_W-1:0]      p1_i,
  input  logic signed [dpw_pkg::P_W-1:0]      p2_i,
  output logic signed [dpw_pkg::WORLD_W-1:0]  world_o
);
  import dpw_pkg::*;

  localparam int unsigned PROD_W = COEF_W + P_W;
  localparam int unsigned SUM_W  = PROD_W + 3;
  localparam int unsigned FRAC   = 16;
  localparam int unsigned SHR_W  = SUM_W - FRAC;

  logic signed [COEF_W-1:0] c0, c1, c2;
  logic signed [PROD_W-1:0] prod0_q, prod1_q, prod2_q;
  logic signed [SUM_W-1:0]  trans_ext;
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [SHR_W-1:0]  shr;
  logic [SHR_W-WORLD_W:0]   top_bits;
  logic signed [WORLD_W-1:0] world_d, world_q;

  assign c0 = signed'(coef_row_i[3*COEF_W-1:2*COEF_W]);
  assign c1 = signed'(coef_row_i[2*COEF_W-1:COEF_W]);
  assign c2 = signed'(coef_row_i[COEF_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_prod) begin
      prod0_q <= c0 * p0_i;
      prod1_q <= c1 * p1_i;
      prod2_q <= c2 * p2_i;
    end
  end

  // Translation is Q.16 metres; the products are Q.32, so shift it up first.
  // The half-LSB rounding constant is folded into the same sum.
  assign trans_ext = SUM_W'(trans_i) <<< FRAC;

  always_comb begin
    sum_d = SUM_W'(prod0_q) + SUM_W'(prod1_q) + SUM_W'(prod2_q) + trans_ext
          + (SUM_W'(1) <<< (FRAC - 1));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sum) begin
      sum_q <= sum_d;
    end
  end

  assign shr      = signed'(sum_q[SUM_W-1:FRAC]);
  assign top_bits = shr[SHR_W-1:WORLD_W-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      world_d = shr[WORLD_W-1:0];
    end else if (shr[SHR_W-1]) begin
      world_d = {1'b1, {(WORLD_W-1){1'b0}}};
    end else begin
      world_d = {1'b0, {(WORLD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_out) begin
      world_q <= world_d;
    end
  end

  assign world_o = world_q;

endmodule

`default_nettype wire

// ===== hw/rtl/depth_pixel_to_world_point_unit.sv =====
// Depth pixel to world point: six register stages. Without an output stall
// it takes one pixel per cycle; a stall on the output holds only the
// stages that are full, and empty stages keep filling.
// A zero depth code is dropped in the first stage. Reset clears all stage
// valid bits and loads the register reset values (a diagonal rotation of one-LSB entries).
`default_nettype none
`include "assert_macros.svh"

module depth_pixel_to_world_point_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  dpw_stream_if.sink                        pix_i,
  dpw_stream_if.source                      pt_o
);
  import dpw_pkg::*;

  localparam int unsigned NSTAGE = 6;
  localparam logic [COORD_W-1:0] CoordMask =
    (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}}
                            : COORD_W'((32'd1 << COORD_BITS) - 32'd1);

  // Configuration registers.
  logic [ROT_ROW_W-1:0]  rot_a_q, rot_b_q, rot_c_q;
  logic [CFG_DATA_W-1:0] trans_q;
  logic [31:0]           center_q, inv_fx_q, inv_fy_q, depth_lsb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_a_q     <= ROT_A_RST;
      rot_b_q     <= ROT_B_RST;
      rot_c_q     <= ROT_C_RST;
      trans_q     <= '0;
      center_q    <= '0;
      inv_fx_q    <= '0;
      inv_fy_q    <= '0;
      depth_lsb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROT_A:     rot_a_q     <= cfg_data_i[ROT_ROW_W-1:0];
        CFG_ROT_B:     rot_b_q     <= cfg_data_i[ROT_ROW_W-1:0];
        CFG_ROT_C:     rot_c_q     <= cfg_data_i[ROT_ROW_W-1:0];
        CFG_TRANS:     trans_q     <= cfg_data_i;
        CFG_CENTER:    center_q    <= cfg_data_i[31:0];
        CFG_INV_FX:    inv_fx_q    <= cfg_data_i[31:0];
        CFG_INV_FY:    inv_fy_q    <= cfg_data_i[31:0];
        CFG_DEPTH_LSB: depth_lsb_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables. A stage loads when it is empty or
  // when the stage after it loads, so bubbles collapse during a stall.
  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || pt_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pix_i.valid && (pix_i.data.depth_code != '0);
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign pix_i.ready = en[0];

  // Colour travels alongside the arithmetic.
  rgb_t rgb_q [NSTAGE];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rgb_q[0] <= '{blue: pix_i.data.blue, green: pix_i.data.green,
                    red: pix_i.data.red};
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        rgb_q[k] <= rgb_q[k-1];
      end
    end
  end

  // Stage 1: pixel offsets from the principal point and depth in Q.16.
  logic [COORD_W-1:0]  col_m, row_m;
  logic signed [16:0]  du_d, dv_d, du_q, dv_q;
  logic [39:0]         z_raw;
  logic [31:0]         z16_d, z16_q1, z16_q2;

  assign col_m = pix_i.data.column & CoordMask;
  assign row_m = pix_i.data.row_index & CoordMask;
  assign du_d  = signed'({1'b0, col_m, 4'b0000}) - signed'({1'b0, center_q[31:16]});
  assign dv_d  = signed'({1'b0, row_m, 4'b0000}) - signed'({1'b0, center_q[15:0]});
  // The product stays below 2^40 even with the rounding half added.
  assign z_raw = pix_i.data.depth_code * depth_lsb_q + 40'd128;
  assign z16_d = z_raw[39:8];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      du_q   <= du_d;
      dv_q   <= dv_d;
      z16_q1 <= z16_d;
    end
  end

  // Stage 2: normalized image coordinates, Q.36 rounded to Q.16.
  logic signed [49:0] pa, pb;
  logic signed [29:0] a_q, b_q;

  assign pa = du_q * signed'({1'b0, inv_fx_q}) + (50'sd1 <<< 19);
  assign pb = dv_q * signed'({1'b0, inv_fy_q}) + (50'sd1 <<< 19);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      a_q    <= pa[49:20];
      b_q    <= pb[49:20];
      z16_q2 <= z16_q1;
    end
  end

  // Stage 3: camera-space x and y, scaled by depth and rounded to Q.16.
  logic signed [62:0]  px, py;
  logic signed [P_W-1:0] p0_q, p1_q, p2_q;

  assign px = a_q * signed'({1'b0, z16_q2}) + (63'sd1 <<< 15);
  assign py = b_q * signed'({1'b0, z16_q2}) + (63'sd1 <<< 15);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p0_q <= px[62:16];
      p1_q <= py[62:16];
      p2_q <= signed'({{(P_W-32){1'b0}}, z16_q2});
    end
  end

  // Stages 4 to 6: rigid transform, one row per world axis.
  row_ctl_t row_ctl;
  logic signed [WORLD_W-1:0] wx, wy, wz;

  assign row_ctl = '{en_prod: en[3], en_sum: en[4], en_out: en[5]};

  dpw_world_row u_row_x (
    .clk_i      (clk_i),
    .ctl_i      (row_ctl),
    .coef_row_i (rot_a_q),
    .trans_i    (signed'(trans_q[3*TRANS_W-1:2*TRANS_W])),
    .p0_i       (p0_q),
    .p1_i       (p1_q),
    .p2_i       (p2_q),
    .world_o    (wx)
  );

  dpw_world_row u_row_y (
    .clk_i      (clk_i),
    .ctl_i      (row_ctl),
    .coef_row_i (rot_b_q),
    .trans_i    (signed'(trans_q[2*TRANS_W-1:TRANS_W])),
    .p0_i       (p0_q),
    .p1_i       (p1_q),
    .p2_i       (p2_q),
    .world_o    (wy)
  );

  dpw_world_row u_row_z (
    .clk_i      (clk_i),
    .ctl_i      (row_ctl),
    .coef_row_i (rot_c_q),
    .trans_i    (signed'(trans_q[TRANS_W-1:0])),
    .p0_i       (p0_q),
    .p1_i       (p1_q),
    .p2_i       (p2_q),
    .world_o    (wz)
  );

  assign pt_o.valid = vld_q[NSTAGE-1];
  assign pt_o.data  = '{world_x:   wx,
                        world_y:   wy,
                        world_z:   wz,
                        out_blue:  rgb_q[NSTAGE-1].blue,
                        out_green: rgb_q[NSTAGE-1].green,
                        out_red:   rgb_q[NSTAGE-1].red};

  // A pixel without depth must never occupy the first stage.
  `ASSERT_NEXT(a_zero_depth_dropped, clk_i, rst_ni,
               en[0] && pix_i.valid && (pix_i.data.depth_code == '0), !vld_q[0])
  // With every stage full and the output stalled, no new pixel is taken.
  `ASSERT_IMPLY(a_full_stall_blocks_input, clk_i, rst_ni,
                (&vld_q) && !pt_o.ready, !pix_i.ready)
  // A full fourth stage that cannot advance keeps its transaction.
  `ASSERT_NEXT(a_held_stage_keeps_item, clk_i, rst_ni,
               vld_q[3] && !en[3], vld_q[3])

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of depth_pixel_to_world_point_unit: a queue-fed pixel driver,
// a point monitor and a fixed-point predictor of the pinhole unprojection and pose.
// Depends on dpw_pkg and dpw_stream_if from the RTL.

module tb_top;
  import dpw_pkg::*;

  localparam int unsigned COORD_BITS = 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 200;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

  localparam longint WORLD_MAX = 64'sd2147483647;
  localparam longint WORLD_MIN = -64'sd2147483648;

  localparam logic [COEF_W-1:0]  COEF_ONE  = 18'h10000;
  localparam logic [COEF_W-1:0]  COEF_MAX  = 18'h1FFFF;
  localparam logic [COEF_W-1:0]  COEF_MIN  = 18'h20000;
  localparam logic [TRANS_W-1:0] TRANS_MAX = 21'h0FFFFF;
  localparam logic [TRANS_W-1:0] TRANS_MIN = 21'h100000;

  typedef enum int {POSE_CAMERA, POSE_RAW, POSE_EDGE} pose_kind_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dpw_stream_if #(.T(pixel_t)) pix_if ();
  dpw_stream_if #(.T(point_t)) pt_if ();

  depth_pixel_to_world_point_unit #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix_i     (pix_if),
    .pt_o      (pt_if)
  );

  // Shadow copy of the pose and camera registers.
  logic [ROT_ROW_W-1:0] rot_row [3];
  logic [3*TRANS_W-1:0] trans_m;
  logic [31:0]          center_m;
  logic [31:0]          inv_fx_m;
  logic [31:0]          inv_fy_m;
  logic [31:0]          depth_step_m;

  pixel_t pending_pixels[$];
  point_t expected_points[$];

  int queued_count;
  int accepted_count;
  int no_depth_count;
  int points_seen;
  int reg_writes;
  int fail_count;
  int cycle_count;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_cnt;
  logic hold_armed;
  logic holding;

  always #5 clk = ~clk;

  function automatic longint round_q(input longint v, input int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [WORLD_W-1:0] clamp_world(input longint v);
    if (v > WORLD_MAX) return WORLD_MAX[WORLD_W-1:0];
    if (v < WORLD_MIN) return WORLD_MIN[WORLD_W-1:0];
    return v[WORLD_W-1:0];
  endfunction

  // Returns 0 for a pixel without depth, else fills in the world point it maps to.
  function automatic bit project_pixel(input pixel_t px, output point_t pt);
    logic [COORD_BITS-1:0] u;
    logic [COORD_BITS-1:0] v;
    logic signed [COEF_W-1:0]  coef;
    logic signed [TRANS_W-1:0] tr;
    longint z16;
    longint du;
    longint dv;
    longint acc;
    longint cam [3];
    logic [WORLD_W-1:0] wrl [3];
    pt = '0;
    if (px.depth_code == 8'd0) return 0;
    u   = px.column[COORD_BITS-1:0];
    v   = px.row_index[COORD_BITS-1:0];
    z16 = (longint'(px.depth_code) * longint'(depth_step_m) + 128) >>> 8;
    du  = longint'({u, 4'b0000}) - longint'(center_m[31:16]);
    dv  = longint'({v, 4'b0000}) - longint'(center_m[15:0]);
    cam[0] = round_q(round_q(du * longint'(inv_fx_m), 20) * z16, 16);
    cam[1] = round_q(round_q(dv * longint'(inv_fy_m), 20) * z16, 16);
    cam[2] = z16;
    for (int i = 0; i < 3; i++) begin
      tr  = trans_m[62 - 21*i -: 21];
      acc = longint'(tr) * 65536;
      for (int j = 0; j < 3; j++) begin
        coef = rot_row[i][53 - 18*j -: 18];
        acc += longint'(coef) * cam[j];
      end
      wrl[i] = clamp_world(round_q(acc, 16));
    end
    pt.world_x   = wrl[0];
    pt.world_y   = wrl[1];
    pt.world_z   = wrl[2];
    pt.out_blue  = px.blue;
    pt.out_green = px.green;
    pt.out_red   = px.red;
    return 1;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    reg_writes++;
    case (idx)
      CFG_ROT_A:     rot_row[0]   = data[ROT_ROW_W-1:0];
      CFG_ROT_B:     rot_row[1]   = data[ROT_ROW_W-1:0];
      CFG_ROT_C:     rot_row[2]   = data[ROT_ROW_W-1:0];
      CFG_TRANS:     trans_m      = data[3*TRANS_W-1:0];
      CFG_CENTER:    center_m     = data[31:0];
      CFG_INV_FX:    inv_fx_m     = data[31:0];
      CFG_INV_FY:    inv_fy_m     = data[31:0];
      CFG_DEPTH_LSB: depth_step_m = data[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pixel(input logic [11:0] u, input logic [11:0] v, input logic [7:0] d,
                           input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    pixel_t px;
    px = '{column: u, row_index: v, depth_code: d, blue: b, green: g, red: r};
    pending_pixels = {pending_pixels, px};
    queued_count++;
  endtask

  // Returns once every queued pixel is taken and every point has arrived, plus
  // enough cycles for dropped zero-depth pixels to leave the pipeline.
  task automatic wait_idle();
    while (accepted_count != queued_count || expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_pose(input pose_kind_e kind);
    logic [COEF_W-1:0]     coef [9];
    logic [TRANS_W-1:0]    tr [3];
    logic [31:0]           word [4];
    logic [CFG_DATA_W-1:0] junk;
    junk = (kind == POSE_RAW) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
    for (int k = 0; k < 9; k++) begin
      case (kind)
        POSE_CAMERA: coef[k] = (k % 4 == 0) ? COEF_ONE - COEF_W'($urandom_range(4096))
                                            : COEF_W'($urandom_range(8192)) - 18'd4096;
        POSE_RAW:    coef[k] = COEF_W'($urandom);
        default: begin
          case ($urandom_range(3))
            0:       coef[k] = COEF_MAX;
            1:       coef[k] = COEF_MIN;
            2:       coef[k] = '0;
            default: coef[k] = COEF_ONE;
          endcase
        end
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      if (kind == POSE_EDGE) begin
        case ($urandom_range(2))
          0:       tr[k] = TRANS_MAX;
          1:       tr[k] = TRANS_MIN;
          default: tr[k] = '0;
        endcase
      end else begin
        tr[k] = TRANS_W'($urandom);
      end
    end
    for (int k = 0; k < 4; k++) begin
      case (kind)
        POSE_CAMERA: begin
          case (k)
            0:       word[k] = {16'($urandom_range(20000, 6000)), 16'($urandom_range(15000, 4000))};
            3:       word[k] = $urandom_range(1 << 23, 1 << 16);
            default: word[k] = $urandom_range(4000000, 200000);
          endcase
        end
        POSE_RAW: word[k] = $urandom;
        default: begin
          case ($urandom_range(2))
            0:       word[k] = '0;
            1:       word[k] = '1;
            default: word[k] = $urandom;
          endcase
        end
      endcase
    end
    write_reg(CFG_ROT_A,     {junk[8:0], coef[0], coef[1], coef[2]});
    write_reg(CFG_ROT_B,     {junk[17:9], coef[3], coef[4], coef[5]});
    write_reg(CFG_ROT_C,     {junk[26:18], coef[6], coef[7], coef[8]});
    write_reg(CFG_TRANS,     {tr[0], tr[1], tr[2]});
    write_reg(CFG_CENTER,    {junk[30:0], word[0]});
    write_reg(CFG_INV_FX,    {junk[62:32], word[1]});
    write_reg(CFG_INV_FY,    {junk[40:10], word[2]});
    write_reg(CFG_DEPTH_LSB, {junk[50:20], word[3]});
    // A write to an unused index must leave the pose untouched.
    write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO)),
              CFG_DATA_W'({$urandom, $urandom}));
  endtask

  // Pixel driver: when the last pixel is taken, the next queued one may be offered.
  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        accepted_count++;
        if (project_pixel(pix_if.data, exp_pt)) expected_points = {expected_points, exp_pt};
        else no_depth_count++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          pix_if.valid <= 1'b1;
          pix_if.data  <= pending_pixels.pop_front();
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Point monitor.
  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      pt_if.ready <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          $error("point transaction with no pending expectation");
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("world_x",   64'(want.world_x),   64'(pt_if.data.world_x));
          check_field("world_y",   64'(want.world_y),   64'(pt_if.data.world_y));
          check_field("world_z",   64'(want.world_z),   64'(pt_if.data.world_z));
          check_field("out_blue",  64'(want.out_blue),  64'(pt_if.data.out_blue));
          check_field("out_green", 64'(want.out_green), 64'(pt_if.data.out_green));
          check_field("out_red",   64'(want.out_red),   64'(pt_if.data.out_red));
        end
      end
      pt_if.ready <= !holding && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // One long output hold, so that the pipeline fills and back-pressures the input.
  assign holding = hold_armed && (hold_cnt < HOLD_CYCLES);

  always @(posedge clk) begin
    if (!rst_n) hold_cnt <= 0;
    else if (holding) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int d_pick;
    logic [7:0] depth;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    pt_if.ready  = 1'b0;
    hold_armed   = 1'b0;
    src_idle_pct = 6;
    snk_idle_pct = 46;
    rot_row[0]   = ROT_A_RST;
    rot_row[1]   = ROT_B_RST;
    rot_row[2]   = ROT_C_RST;
    trans_m      = '0;
    center_m     = '0;
    inv_fx_m     = '0;
    inv_fy_m     = '0;
    depth_step_m = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset pose: zero depth unit, so every point collapses to the origin.
    add_pixel(12'd0, 12'd0, 8'd1, 8'd0, 8'd0, 8'd0);
    add_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(12'd10, 12'd10, 8'd0, 8'd1, 8'd2, 8'd3);
    wait_idle();

    // Typical camera with identity rotation and a small offset.
    write_reg(CFG_ROT_A,     CFG_DATA_W'({COEF_ONE, 18'd0, 18'd0}));
    write_reg(CFG_ROT_B,     CFG_DATA_W'({18'd0, COEF_ONE, 18'd0}));
    write_reg(CFG_ROT_C,     CFG_DATA_W'({18'd0, 18'd0, COEF_ONE}));
    write_reg(CFG_TRANS,     {21'd98304, 21'h1E0000, 21'd16384});
    write_reg(CFG_CENTER,    CFG_DATA_W'({16'd13440, 16'd8400}));
    write_reg(CFG_INV_FX,    CFG_DATA_W'(32'd901570));
    write_reg(CFG_INV_FY,    CFG_DATA_W'(32'd901570));
    write_reg(CFG_DEPTH_LSB, CFG_DATA_W'(32'd470420));
    add_pixel(12'd0, 12'd0, 8'd1, 8'hAA, 8'h55, 8'hAA);
    add_pixel(12'hFFF, 12'd0, 8'hFF, 8'h55, 8'hAA, 8'h55);
    add_pixel(12'd0, 12'hFFF, 8'hFF, 8'h0F, 8'hF0, 8'h0F);
    add_pixel(12'hFFF, 12'hFFF, 8'h80, 8'hF0, 8'h0F, 8'hF0);
    add_pixel(12'd840, 12'd525, 8'd100, 8'd7, 8'd8, 8'd9);
    add_pixel(12'd1, 12'd1, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();

    // Every coefficient and offset at its largest value: saturates high.
    write_reg(CFG_ROT_A,     CFG_DATA_W'({COEF_MAX, COEF_MAX, COEF_MAX}));
    write_reg(CFG_ROT_B,     CFG_DATA_W'({COEF_MAX, COEF_MAX, COEF_MAX}));
    write_reg(CFG_ROT_C,     CFG_DATA_W'({COEF_MAX, COEF_MAX, COEF_MAX}));
    write_reg(CFG_TRANS,     {TRANS_MAX, TRANS_MAX, TRANS_MAX});
    write_reg(CFG_CENTER,    CFG_DATA_W'(32'd0));
    write_reg(CFG_INV_FX,    CFG_DATA_W'(32'hFFFF_FFFF));
    write_reg(CFG_INV_FY,    CFG_DATA_W'(32'hFFFF_FFFF));
    write_reg(CFG_DEPTH_LSB, CFG_DATA_W'(32'hFFFF_FFFF));
    add_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'h12, 8'h34, 8'h56);
    add_pixel(12'd0, 12'd0, 8'hFF, 8'h65, 8'h43, 8'h21);
    wait_idle();

    // Most negative coefficients and offsets; the center sits on the last pixel.
    write_reg(CFG_ROT_A,  CFG_DATA_W'({COEF_MIN, COEF_MIN, COEF_MIN}));
    write_reg(CFG_ROT_B,  CFG_DATA_W'({COEF_MIN, COEF_MIN, COEF_MIN}));
    write_reg(CFG_ROT_C,  CFG_DATA_W'({COEF_MIN, COEF_MIN, COEF_MIN}));
    write_reg(CFG_TRANS,  {TRANS_MIN, TRANS_MIN, TRANS_MIN});
    write_reg(CFG_CENTER, CFG_DATA_W'({16'hFFF0, 16'hFFF0}));
    add_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'd1, 8'd1, 8'd1);
    add_pixel(12'd0, 12'd0, 8'hFF, 8'd2, 8'd2, 8'd2);
    add_pixel(12'hFFF, 12'd0, 8'h80, 8'd3, 8'd3, 8'd3);
    wait_idle();

    // Zero focal terms: x and y vanish before the transform.
    write_reg(CFG_ROT_A,     CFG_DATA_W'({COEF_ONE, 18'd0, 18'd0}));
    write_reg(CFG_ROT_B,     CFG_DATA_W'({18'd0, COEF_ONE, 18'd0}));
    write_reg(CFG_ROT_C,     CFG_DATA_W'({18'd0, 18'd0, COEF_ONE}));
    write_reg(CFG_TRANS,     '0);
    write_reg(CFG_CENTER,    CFG_DATA_W'({16'd13440, 16'd8400}));
    write_reg(CFG_INV_FX,    CFG_DATA_W'(32'd0));
    write_reg(CFG_INV_FY,    CFG_DATA_W'(32'd0));
    write_reg(CFG_DEPTH_LSB, CFG_DATA_W'(32'd470420));
    add_pixel(12'd100, 12'd200, 8'd50, 8'd4, 8'd5, 8'd6);
    wait_idle();

    write_reg(CFG_IDX_SPARE_HI, '1);
    add_pixel(12'd5, 12'd5, 8'd5, 8'd5, 8'd5, 8'd5);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph == 2) begin
        src_idle_pct <= 46;
        snk_idle_pct <= 6;
      end else if (ph == 4) begin
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
      end
      load_pose(pose_kind_e'(ph % 3));
      if (ph == 5) hold_armed <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        d_pick = $urandom_range(15);
        depth  = (d_pick == 0) ? 8'd0 : (d_pick == 1) ? 8'hFF : 8'($urandom_range(255, 1));
        add_pixel(12'($urandom), 12'($urandom), depth,
                  8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    wait_idle();
    if (expected_points.size() != 0) begin
      $error("%0d points never arrived", expected_points.size());
      fail_count++;
    end
    $display("Covered %0d pixels (%0d without depth) and checked %0d points,",
             accepted_count, no_depth_count, points_seen);
    $display("over %0d register writes and a %0d-cycle output hold.", reg_writes, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
